FILE: hw/rtl/grid_surface_bilinear_interp_core_macros.svh
// Assertion macros used by the checker file of the grid surface core.
// No dependencies; included by the checker by bare file name.
`ifndef GRID_SURFACE_BILINEAR_INTERP_CORE_MACROS_SVH
`define GRID_SURFACE_BILINEAR_INTERP_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GSBI_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("grid surface check failed (same cycle)");

// Consequent must hold in the cycle after the antecedent.
`define GSBI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("grid surface check failed (next cycle)");

`endif

FILE: hw/rtl/gsbi_pkg.sv
// Package of the grid surface bilinear core: widths, codes, request structs.
// No dependencies; imported by every module of the block.
`default_nettype none

package gsbi_pkg;

    localparam int VAL_W           = 32;
    localparam int MODE_W          = 2;
    localparam int NODE_W          = 6;
    localparam int CNT_W           = 7;
    localparam int CFG_IDX_W       = 2;
    localparam int IDX_EXT_W       = 11;
    localparam int FRAC_W          = 16;
    localparam int RATIO_W         = 17;
    localparam int WGT_W           = 18;
    localparam int DIFF_W          = 33;
    localparam int DIV_NUM_W       = 48;
    localparam int DIV_DEN_W       = 32;
    localparam int MAC_A_W         = 50;
    localparam int ACC_W           = 66;
    localparam int DEF_MAX_X_NODES = 64;
    localparam int DEF_MAX_Y_NODES = 64;

    localparam logic [RATIO_W-1:0]   RATIO_ONE       = RATIO_W'(65536);
    localparam logic [CNT_W-1:0]     CFG_NODES_RESET = CNT_W'(64);
    localparam logic [CFG_IDX_W-1:0] CFG_X_NODES     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_Y_NODES     = CFG_IDX_W'(1);

    // Multiply-accumulate schedule: steps at which a finished pair sum is taken.
    localparam logic [3:0] MAC_ISSUE_STEPS = 4'd10;
    localparam logic [3:0] STEP_A0         = 4'd3;
    localparam logic [3:0] STEP_A1         = 4'd5;
    localparam logic [3:0] STEP_NUM_X      = 4'd7;
    localparam logic [3:0] STEP_NUM_Y      = 4'd9;
    localparam logic [3:0] STEP_HEIGHT     = 4'd11;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD_X = 2'd0,
        MODE_LOAD_Y = 2'd1,
        MODE_LOAD_Z = 2'd2,
        MODE_QUERY  = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_C0_ADDR,
        ST_C0_DATA,
        ST_SEARCH,
        ST_RATIO_DIV,
        ST_Z_READ,
        ST_MAC,
        ST_SLOPE_X,
        ST_SLOPE_X_WAIT,
        ST_SLOPE_Y,
        ST_SLOPE_Y_WAIT,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic              x_we;
        logic              y_we;
        logic              z_we;
        logic [NODE_W-1:0] i;
        logic [NODE_W-1:0] j;
        logic [VAL_W-1:0]  data;
    } t_load_req;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                      en;
        logic                      first;
        logic signed [MAC_A_W-1:0] a;
        logic signed [WGT_W-1:0]   b;
    } t_mac_op;

endpackage

`default_nettype wire

FILE: hw/rtl/gsbi_store.sv
// Node coordinate and height memories of the grid surface core.
// Depends on gsbi_pkg; one write port for loads, registered read ports.
`default_nettype none

module gsbi_store #(
    parameter int MAX_X_NODES = gsbi_pkg::DEF_MAX_X_NODES,
    parameter int MAX_Y_NODES = gsbi_pkg::DEF_MAX_Y_NODES
) (
    input  wire logic                                       i_clk,
    input  wire gsbi_pkg::t_load_req                        i_load,
    input  wire logic [$clog2(MAX_X_NODES)-1:0]             i_x_addr,
    input  wire logic [$clog2(MAX_Y_NODES)-1:0]             i_y_addr,
    input  wire logic [$clog2(MAX_X_NODES)-1:0]             i_z_i,
    input  wire logic [$clog2(MAX_Y_NODES)-1:0]             i_z_j,
    output logic      [gsbi_pkg::VAL_W-1:0]                 o_x_data,
    output logic      [gsbi_pkg::VAL_W-1:0]                 o_y_data,
    output logic      [gsbi_pkg::VAL_W-1:0]                 o_z_data
);
    import gsbi_pkg::*;

    localparam int XW = $clog2(MAX_X_NODES);
    localparam int YW = $clog2(MAX_Y_NODES);
    localparam int ZW = $clog2(MAX_X_NODES * MAX_Y_NODES);

    logic [VAL_W-1:0] r_x_mem [MAX_X_NODES];
    logic [VAL_W-1:0] r_y_mem [MAX_Y_NODES];
    logic [VAL_W-1:0] r_z_mem [MAX_X_NODES * MAX_Y_NODES];

    logic [IDX_EXT_W-1:0] w_i_ext;
    logic [IDX_EXT_W-1:0] w_j_ext;
    logic                 w_i_ok;
    logic                 w_j_ok;
    logic [ZW-1:0]        w_z_waddr;
    logic [ZW-1:0]        w_z_raddr;

    // Load indices beyond the grid are dropped.
    always_comb begin
        w_i_ext   = IDX_EXT_W'(i_load.i);
        w_j_ext   = IDX_EXT_W'(i_load.j);
        w_i_ok    = w_i_ext < IDX_EXT_W'(MAX_X_NODES);
        w_j_ok    = w_j_ext < IDX_EXT_W'(MAX_Y_NODES);
        w_z_waddr = ZW'(w_i_ext[XW-1:0]) * ZW'(MAX_Y_NODES) + ZW'(w_j_ext[YW-1:0]);
        w_z_raddr = ZW'(i_z_i) * ZW'(MAX_Y_NODES) + ZW'(i_z_j);
    end

    // Coordinate memories.
    always_ff @(posedge i_clk) begin
        if (i_load.x_we && w_i_ok) begin
            r_x_mem[w_i_ext[XW-1:0]] <= i_load.data;
        end
        if (i_load.y_we && w_j_ok) begin
            r_y_mem[w_j_ext[YW-1:0]] <= i_load.data;
        end
        o_x_data <= r_x_mem[i_x_addr];
        o_y_data <= r_y_mem[i_y_addr];
    end

    // Height memory, row i holds all y nodes of x node i.
    always_ff @(posedge i_clk) begin
        if (i_load.z_we && w_i_ok && w_j_ok) begin
            r_z_mem[w_z_waddr] <= i_load.data;
        end
        o_z_data <= r_z_mem[w_z_raddr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/gsbi_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on gsbi_pkg; shared by the ratio and slope divisions.
`default_nettype none

module gsbi_divider (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire gsbi_pkg::t_div_req             i_req,
    output logic                                o_done,
    output logic [gsbi_pkg::DIV_NUM_W-1:0]      o_quo
);
    import gsbi_pkg::*;

    localparam int CW = $clog2(DIV_NUM_W);

    logic                 r_busy;
    logic                 r_done;
    logic [CW-1:0]        r_cnt;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_NUM_W-1:0] r_quo;

    logic [DIV_DEN_W:0]   w_shift;
    logic [DIV_DEN_W:0]   w_diff;
    logic                 w_ge;

    // One trial subtraction of the shifted remainder.
    always_comb begin
        w_shift = {r_rem, r_quo[DIV_NUM_W-1]};
        w_diff  = w_shift - {1'b0, r_den};
        w_ge    = w_shift >= {1'b0, r_den};
    end

    // Control of the iteration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(DIV_NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient, the dividend shifts out as quotient bits shift in.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_den <= i_req.den;
            r_quo <= i_req.num;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIV_DEN_W-1:0] : w_shift[DIV_DEN_W-1:0];
            r_quo <= {r_quo[DIV_NUM_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

FILE: hw/rtl/gsbi_mac.sv
// Shared signed multiply-accumulate unit with a registered product.
// Depends on gsbi_pkg; the product register feeds the accumulator.
`default_nettype none

module gsbi_mac (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire gsbi_pkg::t_mac_op                i_op,
    output logic signed [gsbi_pkg::ACC_W-1:0]     o_acc
);
    import gsbi_pkg::*;

    logic signed [MAC_A_W-1:0]       w_a;
    logic signed [WGT_W-1:0]         w_b;
    logic signed [MAC_A_W+WGT_W-1:0] w_prod;

    logic                    r_en_d;
    logic                    r_first_d;
    logic signed [ACC_W-1:0] r_prod;
    logic signed [ACC_W-1:0] r_acc;

    // Product of the current operands.
    always_comb begin
        w_a    = i_op.a;
        w_b    = i_op.b;
        w_prod = w_a * w_b;
    end

    // Control delay that follows the product register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en_d    <= 1'b0;
            r_first_d <= 1'b0;
        end else begin
            r_en_d    <= i_op.en;
            r_first_d <= i_op.first;
        end
    end

    // Product register, then the accumulator.
    always_ff @(posedge i_clk) begin
        r_prod <= $signed(w_prod[ACC_W-1:0]);
        if (r_en_d) begin
            r_acc <= r_first_d ? r_prod : r_acc + r_prod;
        end
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

FILE: hw/rtl/grid_surface_bilinear_interp_core.sv
// Top level of the grid surface bilinear core: command port, sequencer, datapath.
// Depends on gsbi_pkg, gsbi_store, gsbi_divider and gsbi_mac.
//
// Usage. A request is taken when start is high and busy is low. Modes 0, 1 and 2
// load one x coordinate, y coordinate or height in that cycle; they give no result
// and busy stays low. Mode 3 queries a point: busy rises, and the result shows on
// the o_ ports with o_valid high for exactly one cycle, the cycle busy falls.
// The receiver cannot stall; each result must be taken in its strobe cycle.
// A query searches each axis in turn by a linear node search of up to the node
// count in steps, one coordinate memory read per cycle, and then needs from 0 to 4
// divisions on the shared restoring divider, one quotient bit per cycle: one per
// axis whose point lies inside the grid, one per axis slope with nonzero cell
// width. One shared multiplier does all products. The config channel is always
// ready; it must be written only while the block is idle, which the block
// itself does not enforce. Reset clears the sequencer and sets both node counts
// to 64; the memories keep undefined contents until loaded.
`default_nettype none

module grid_surface_bilinear_interp_core #(
    parameter int MAX_X_NODES = gsbi_pkg::DEF_MAX_X_NODES,
    parameter int MAX_Y_NODES = gsbi_pkg::DEF_MAX_Y_NODES
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [gsbi_pkg::MODE_W-1:0]        i_mode,
    input  wire logic [gsbi_pkg::NODE_W-1:0]        i_node_i,
    input  wire logic [gsbi_pkg::NODE_W-1:0]        i_node_j,
    input  wire logic signed [gsbi_pkg::VAL_W-1:0]  i_load_value,
    input  wire logic signed [gsbi_pkg::VAL_W-1:0]  i_query_x,
    input  wire logic signed [gsbi_pkg::VAL_W-1:0]  i_query_y,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [gsbi_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [gsbi_pkg::CNT_W-1:0]         i_cfg_data,
    output logic                                    o_valid,
    output logic signed [gsbi_pkg::VAL_W-1:0]       o_height,
    output logic signed [gsbi_pkg::VAL_W-1:0]       o_slope_x,
    output logic signed [gsbi_pkg::VAL_W-1:0]       o_slope_y,
    output logic [gsbi_pkg::NODE_W-1:0]             o_cell_x,
    output logic [gsbi_pkg::NODE_W-1:0]             o_cell_y,
    output logic                                    o_saturated
);
    import gsbi_pkg::*;

    localparam int XW   = $clog2(MAX_X_NODES);
    localparam int YW   = $clog2(MAX_Y_NODES);
    localparam int MAXN = (MAX_X_NODES > MAX_Y_NODES) ? MAX_X_NODES : MAX_Y_NODES;
    localparam int NW   = $clog2(MAXN + 1);

    // Node count register, clamped to one and to the grid size.
    function automatic logic [NW-1:0] clamp_count(input logic [CNT_W-1:0] n, input int max_n);
        logic [NW-1:0] res;
        if (n == '0) begin
            res = NW'(1);
        end else if (int'(n) > max_n) begin
            res = NW'(max_n);
        end else begin
            res = NW'(n);
        end
        return res;
    endfunction

    // Signed slope from quotient magnitude and sign, saturated; flag in the top bit.
    function automatic logic [VAL_W:0] sat_slope(input logic [DIV_NUM_W-1:0] q, input logic neg);
        logic [DIV_NUM_W-1:0] nq;
        logic [VAL_W:0]       res;
        nq = -q;
        if (neg) begin
            if (q > DIV_NUM_W'(64'h8000_0000)) begin
                res = {1'b1, 32'h8000_0000};
            end else begin
                res = {1'b0, nq[VAL_W-1:0]};
            end
        end else if (q > DIV_NUM_W'(64'h7FFF_FFFF)) begin
            res = {1'b1, 32'h7FFF_FFFF};
        end else begin
            res = {1'b0, q[VAL_W-1:0]};
        end
        return res;
    endfunction

    t_state r_state;
    t_state n_state;

    logic [CNT_W-1:0]          r_x_cfg;
    logic [CNT_W-1:0]          r_y_cfg;
    logic                      r_ax;
    logic signed [VAL_W-1:0]   r_qx;
    logic signed [VAL_W-1:0]   r_qy;
    logic signed [VAL_W-1:0]   r_prev;
    logic [NW-1:0]             r_k;
    logic                      r_below;
    logic [NW-1:0]             r_ix;
    logic [NW-1:0]             r_iy;
    logic [RATIO_W-1:0]        r_rx;
    logic [RATIO_W-1:0]        r_ry;
    logic signed [DIFF_W-1:0]  r_wx;
    logic signed [DIFF_W-1:0]  r_wy;
    logic [2:0]                r_zc;
    logic signed [VAL_W-1:0]   r_z00;
    logic signed [VAL_W-1:0]   r_z01;
    logic signed [VAL_W-1:0]   r_z10;
    logic signed [VAL_W-1:0]   r_z11;
    logic [3:0]                r_step;
    logic signed [MAC_A_W-1:0] r_a0;
    logic signed [MAC_A_W-1:0] r_a1;
    logic signed [MAC_A_W-1:0] r_num_x;
    logic signed [MAC_A_W-1:0] r_num_y;
    logic signed [VAL_W-1:0]   r_h;
    logic signed [VAL_W-1:0]   r_sx;
    logic signed [VAL_W-1:0]   r_sy;
    logic                      r_sat;
    logic                      r_valid;

    logic                      w_accept;
    logic [NW-1:0]             w_nx;
    logic [NW-1:0]             w_ny;
    logic [NW-1:0]             w_n;
    logic signed [VAL_W-1:0]   w_q;
    logic signed [VAL_W-1:0]   w_cur;
    logic signed [DIFF_W-1:0]  w_diff_qp;
    logic signed [DIFF_W-1:0]  w_diff_cp;
    logic                      w_in_cell;
    logic                      w_last;
    logic [NW-1:0]             w_rd_addr;
    logic [NW-1:0]             w_ix1;
    logic [NW-1:0]             w_iy1;
    logic [NW-1:0]             w_zi;
    logic [NW-1:0]             w_zj;
    logic signed [WGT_W-1:0]   w_wx0;
    logic signed [WGT_W-1:0]   w_wx1;
    logic signed [WGT_W-1:0]   w_wy0;
    logic signed [WGT_W-1:0]   w_wy1;
    logic signed [ACC_W-1:0]   w_acc;
    logic signed [ACC_W-1:0]   w_hsum;
    logic signed [MAC_A_W-1:0] w_num_x_mag;
    logic signed [MAC_A_W-1:0] w_num_y_mag;
    logic signed [DIFF_W-1:0]  w_wx_mag;
    logic signed [DIFF_W-1:0]  w_wy_mag;
    logic [VAL_W:0]            w_slope;
    logic                      w_axis_end;
    logic                      w_set_idx;
    logic [NW-1:0]             w_idx_val;
    logic                      w_set_ratio;
    logic [RATIO_W-1:0]        w_ratio_val;
    logic                      w_set_width;
    logic signed [DIFF_W-1:0]  w_width_val;
    logic                      w_div_done;
    logic [DIV_NUM_W-1:0]      w_div_quo;
    logic [VAL_W-1:0]          w_x_data;
    logic [VAL_W-1:0]          w_y_data;
    logic [VAL_W-1:0]          w_z_data;
    t_load_req                 w_load;
    t_div_req                  w_div;
    t_mac_op                   w_mac;

    // Shared views of the axis under search and of the cell weights.
    always_comb begin
        w_accept    = start && !busy;
        w_nx        = clamp_count(r_x_cfg, MAX_X_NODES);
        w_ny        = clamp_count(r_y_cfg, MAX_Y_NODES);
        w_n         = r_ax ? w_ny : w_nx;
        w_q         = r_ax ? r_qy : r_qx;
        w_cur       = r_ax ? $signed(w_y_data) : $signed(w_x_data);
        w_diff_qp   = DIFF_W'(w_q) - DIFF_W'(r_prev);
        w_diff_cp   = DIFF_W'(w_cur) - DIFF_W'(r_prev);
        w_in_cell   = (w_q >= r_prev) && (w_q < w_cur);
        w_last      = r_k == (w_n - NW'(1));
        w_ix1       = (w_nx > NW'(1)) ? r_ix + NW'(1) : r_ix;
        w_iy1       = (w_ny > NW'(1)) ? r_iy + NW'(1) : r_iy;
        w_wx1       = $signed({1'b0, r_rx});
        w_wx0       = $signed({1'b0, RATIO_ONE}) - w_wx1;
        w_wy1       = $signed({1'b0, r_ry});
        w_wy0       = $signed({1'b0, RATIO_ONE}) - w_wy1;
        w_hsum      = w_acc + (ACC_W'(1) <<< 31);
        w_num_x_mag = r_num_x[MAC_A_W-1] ? -r_num_x : r_num_x;
        w_num_y_mag = r_num_y[MAC_A_W-1] ? -r_num_y : r_num_y;
        w_wx_mag    = r_wx[DIFF_W-1] ? -r_wx : r_wx;
        w_wy_mag    = r_wy[DIFF_W-1] ? -r_wy : r_wy;
        w_slope     = (r_state == ST_SLOPE_X_WAIT)
                    ? sat_slope(w_div_quo, r_num_x[MAC_A_W-1] ^ r_wx[DIFF_W-1])
                    : sat_slope(w_div_quo, r_num_y[MAC_A_W-1] ^ r_wy[DIFF_W-1]);
    end

    // Height corner addresses in the order z00, z01, z10, z11.
    always_comb begin
        case (r_zc)
            3'd0: begin
                w_zi = r_ix;
                w_zj = r_iy;
            end
            3'd1: begin
                w_zi = r_ix;
                w_zj = w_iy1;
            end
            3'd2: begin
                w_zi = w_ix1;
                w_zj = r_iy;
            end
            default: begin
                w_zi = w_ix1;
                w_zj = w_iy1;
            end
        endcase
    end

    // Load requests go straight to the memories.
    always_comb begin
        w_load.x_we = w_accept && (i_mode == MODE_LOAD_X);
        w_load.y_we = w_accept && (i_mode == MODE_LOAD_Y);
        w_load.z_we = w_accept && (i_mode == MODE_LOAD_Z);
        w_load.i    = i_node_i;
        w_load.j    = i_node_j;
        w_load.data = i_load_value;
    end

    // Multiply-accumulate schedule, two terms per sum.
    always_comb begin
        w_mac.en    = (r_state == ST_MAC) && (r_step < MAC_ISSUE_STEPS);
        w_mac.first = !r_step[0];
        case (r_step)
            4'd0: begin
                w_mac.a = MAC_A_W'(r_z00);
                w_mac.b = w_wx0;
            end
            4'd1: begin
                w_mac.a = MAC_A_W'(r_z10);
                w_mac.b = w_wx1;
            end
            4'd2: begin
                w_mac.a = MAC_A_W'(r_z01);
                w_mac.b = w_wx0;
            end
            4'd3: begin
                w_mac.a = MAC_A_W'(r_z11);
                w_mac.b = w_wx1;
            end
            4'd4: begin
                w_mac.a = MAC_A_W'(r_z10) - MAC_A_W'(r_z00);
                w_mac.b = w_wy0;
            end
            4'd5: begin
                w_mac.a = MAC_A_W'(r_z11) - MAC_A_W'(r_z01);
                w_mac.b = w_wy1;
            end
            4'd6: begin
                w_mac.a = MAC_A_W'(r_z01) - MAC_A_W'(r_z00);
                w_mac.b = w_wx0;
            end
            4'd7: begin
                w_mac.a = MAC_A_W'(r_z11) - MAC_A_W'(r_z10);
                w_mac.b = w_wx1;
            end
            4'd8: begin
                w_mac.a = r_a0;
                w_mac.b = w_wy0;
            end
            default: begin
                w_mac.a = r_a1;
                w_mac.b = w_wy1;
            end
        endcase
    end

    // Sequencer: next state, memory addresses, divider requests, axis updates.
    always_comb begin
        n_state     = r_state;
        w_rd_addr   = r_k + NW'(1);
        w_div.start = 1'b0;
        w_div.num   = {w_diff_qp[DIV_DEN_W-1:0], {FRAC_W{1'b0}}};
        w_div.den   = w_diff_cp[DIV_DEN_W-1:0];
        w_axis_end  = 1'b0;
        w_set_idx   = 1'b0;
        w_idx_val   = '0;
        w_set_ratio = 1'b0;
        w_ratio_val = '0;
        w_set_width = 1'b0;
        w_width_val = w_diff_cp;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_mode == MODE_QUERY)) begin
                    n_state = ST_C0_ADDR;
                end
            end
            ST_C0_ADDR: begin
                w_rd_addr = '0;
                n_state   = ST_C0_DATA;
            end
            ST_C0_DATA: begin
                w_rd_addr = NW'(1);
                if (w_n == NW'(1)) begin
                    w_axis_end  = 1'b1;
                    w_set_idx   = 1'b1;
                    w_set_ratio = 1'b1;
                    w_set_width = 1'b1;
                    w_width_val = '0;
                end else begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (r_below) begin
                    w_axis_end  = 1'b1;
                    w_set_idx   = 1'b1;
                    w_set_ratio = 1'b1;
                    w_set_width = 1'b1;
                end else if (w_in_cell) begin
                    w_div.start = 1'b1;
                    w_set_idx   = 1'b1;
                    w_idx_val   = r_k - NW'(1);
                    w_set_width = 1'b1;
                    n_state     = ST_RATIO_DIV;
                end else if (w_last) begin
                    w_axis_end  = 1'b1;
                    w_set_idx   = 1'b1;
                    w_idx_val   = w_n - NW'(2);
                    w_set_ratio = 1'b1;
                    w_ratio_val = RATIO_ONE;
                    w_set_width = 1'b1;
                end
            end
            ST_RATIO_DIV: begin
                if (w_div_done) begin
                    w_axis_end  = 1'b1;
                    w_set_ratio = 1'b1;
                    w_ratio_val = w_div_quo[RATIO_W-1:0];
                end
            end
            ST_Z_READ: begin
                if (r_zc == 3'd4) begin
                    n_state = ST_MAC;
                end
            end
            ST_MAC: begin
                if (r_step == STEP_HEIGHT) begin
                    n_state = ST_SLOPE_X;
                end
            end
            ST_SLOPE_X: begin
                w_div.num = w_num_x_mag[DIV_NUM_W-1:0];
                w_div.den = w_wx_mag[DIV_DEN_W-1:0];
                if ((w_nx > NW'(1)) && (r_wx != '0)) begin
                    w_div.start = 1'b1;
                    n_state     = ST_SLOPE_X_WAIT;
                end else begin
                    n_state = ST_SLOPE_Y;
                end
            end
            ST_SLOPE_X_WAIT: begin
                if (w_div_done) begin
                    n_state = ST_SLOPE_Y;
                end
            end
            ST_SLOPE_Y: begin
                w_div.num = w_num_y_mag[DIV_NUM_W-1:0];
                w_div.den = w_wy_mag[DIV_DEN_W-1:0];
                if ((w_ny > NW'(1)) && (r_wy != '0)) begin
                    w_div.start = 1'b1;
                    n_state     = ST_SLOPE_Y_WAIT;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_SLOPE_Y_WAIT: begin
                if (w_div_done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        // After x comes y, after y the corner reads.
        if (w_axis_end) begin
            n_state = r_ax ? ST_Z_READ : ST_C0_ADDR;
        end
    end

    // State register and control counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            r_ax    <= 1'b0;
            r_zc    <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= r_state == ST_FINISH;
            if (r_state == ST_IDLE) begin
                r_ax <= 1'b0;
            end else if (w_axis_end) begin
                r_ax <= 1'b1;
            end
            r_zc   <= (r_state == ST_Z_READ) ? r_zc + 3'd1 : '0;
            r_step <= (r_state == ST_MAC) ? r_step + 4'd1 : '0;
        end
    end

    // Node count registers; the port is always ready.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_cfg <= CFG_NODES_RESET;
            r_y_cfg <= CFG_NODES_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_X_NODES) begin
                r_x_cfg <= i_cfg_data;
            end else if (i_cfg_index == CFG_Y_NODES) begin
                r_y_cfg <= i_cfg_data;
            end
        end
    end

    // Search registers and per-axis cell results.
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_mode == MODE_QUERY)) begin
            r_qx <= i_query_x;
            r_qy <= i_query_y;
        end
        if (r_state == ST_C0_DATA) begin
            r_prev  <= w_cur;
            r_k     <= NW'(1);
            r_below <= w_q <= w_cur;
        end else if ((r_state == ST_SEARCH) && !r_below && !w_in_cell && !w_last) begin
            r_prev <= w_cur;
            r_k    <= r_k + NW'(1);
        end
        if (w_set_idx) begin
            if (r_ax) begin
                r_iy <= w_idx_val;
            end else begin
                r_ix <= w_idx_val;
            end
        end
        if (w_set_ratio) begin
            if (r_ax) begin
                r_ry <= w_ratio_val;
            end else begin
                r_rx <= w_ratio_val;
            end
        end
        if (w_set_width) begin
            if (r_ax) begin
                r_wy <= w_width_val;
            end else begin
                r_wx <= w_width_val;
            end
        end
    end

    // Corner heights arrive in the cycle after their address.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_Z_READ) begin
            case (r_zc)
                3'd1: r_z00 <= $signed(w_z_data);
                3'd2: r_z01 <= $signed(w_z_data);
                3'd3: r_z10 <= $signed(w_z_data);
                3'd4: r_z11 <= $signed(w_z_data);
                default: ;
            endcase
        end
    end

    // Finished sums from the accumulator, rounded height and slopes.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_MAC) begin
            case (r_step)
                STEP_A0:     r_a0    <= w_acc[MAC_A_W-1:0];
                STEP_A1:     r_a1    <= w_acc[MAC_A_W-1:0];
                STEP_NUM_X:  r_num_x <= w_acc[MAC_A_W-1:0];
                STEP_NUM_Y:  r_num_y <= w_acc[MAC_A_W-1:0];
                STEP_HEIGHT: r_h     <= w_hsum[2*VAL_W-1:VAL_W];
                default: ;
            endcase
        end
        if (r_state == ST_Z_READ) begin
            r_sx  <= '0;
            r_sy  <= '0;
            r_sat <= 1'b0;
        end else if (w_div_done && (r_state == ST_SLOPE_X_WAIT)) begin
            r_sx  <= w_slope[VAL_W-1:0];
            r_sat <= r_sat | w_slope[VAL_W];
        end else if (w_div_done && (r_state == ST_SLOPE_Y_WAIT)) begin
            r_sy  <= w_slope[VAL_W-1:0];
            r_sat <= r_sat | w_slope[VAL_W];
        end
    end

    // Result registers, loaded as the sequencer finishes.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_FINISH) begin
            o_height    <= r_h;
            o_slope_x   <= r_sx;
            o_slope_y   <= r_sy;
            o_cell_x    <= NODE_W'(r_ix);
            o_cell_y    <= NODE_W'(r_iy);
            o_saturated <= r_sat;
        end
    end

    assign busy        = r_state != ST_IDLE;
    assign o_valid     = r_valid;
    assign o_cfg_ready = 1'b1;

    gsbi_store #(
        .MAX_X_NODES (MAX_X_NODES),
        .MAX_Y_NODES (MAX_Y_NODES)
    ) u_store (
        .i_clk    (i_clk),
        .i_load   (w_load),
        .i_x_addr (w_rd_addr[XW-1:0]),
        .i_y_addr (w_rd_addr[YW-1:0]),
        .i_z_i    (w_zi[XW-1:0]),
        .i_z_j    (w_zj[YW-1:0]),
        .o_x_data (w_x_data),
        .o_y_data (w_y_data),
        .o_z_data (w_z_data)
    );

    gsbi_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    gsbi_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_mac),
        .o_acc   (w_acc)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/gsbi_checker.sv
// Port-level checks of the grid surface core's command and result timing.
// Depends on gsbi_pkg and the assertion macro header; bound to the top level.
`default_nettype none

`include "grid_surface_bilinear_interp_core_macros.svh"

module gsbi_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        start,
    input wire logic                        busy,
    input wire logic [gsbi_pkg::MODE_W-1:0] i_mode,
    input wire logic                        o_valid
);
    import gsbi_pkg::*;

    // A query occupies the block; a load does not.
    `GSBI_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, start && !busy && (i_mode == MODE_QUERY), busy)
    `GSBI_ASSERT_NEXT(a_load_free, i_clk, i_rst_n, start && !busy && (i_mode != MODE_QUERY), !busy)

    // The result strobe lasts one cycle and comes exactly as busy drops.
    `GSBI_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_valid, !o_valid)
    `GSBI_ASSERT_SAME(a_result_at_end, i_clk, i_rst_n, $fell(busy), o_valid)

endmodule

bind grid_surface_bilinear_interp_core gsbi_checker u_gsbi_checker (.*);

`default_nettype wire
